/* src/sound_level_smoother_unit_macros.svh */
// Assertion macros for the sound level smoother RTL.
// Included by the top level; needs no other file.
`ifndef SOUND_LEVEL_SMOOTHER_UNIT_MACROS_SVH
`define SOUND_LEVEL_SMOOTHER_UNIT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define SLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check whose property must hold in the cycle after the condition, disabled during reset.
`define SLS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* src/sls_pkg.sv */
// Shared constants and types of the sound level smoother.
// No dependencies; used by sls_average and sound_level_smoother_unit.
`default_nettype none

package sls_pkg;

    localparam int DEFAULT_WINDOW      = 5;
    localparam int DEFAULT_SAMPLE_BITS = 12;

    localparam int DB_W      = 16;
    localparam int SCALE_W   = 24;
    localparam int LIMIT_W   = 16;
    localparam int BETA_W    = 17;
    localparam int ACC_W     = 26;
    localparam int ACC_FRAC  = 10;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [DB_W-1:0]    DB_MAX         = '1;
    localparam logic [BETA_W-1:0]  BETA_ONE       = BETA_W'(65536);
    localparam logic [SCALE_W-1:0] RST_DB_SCALE   = SCALE_W'(676008);
    localparam logic [LIMIT_W-1:0] RST_JUMP_LIMIT = LIMIT_W'(2560);
    localparam logic [LIMIT_W-1:0] RST_HOLD_BAND  = LIMIT_W'(512);
    localparam logic [BETA_W-1:0]  RST_BETA       = BETA_W'(6554);

    localparam logic [CFG_IDX_W-1:0] CFG_DB_SCALE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_BAND   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_BETA = CFG_IDX_W'(3);

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } t_avg_en;

endpackage

`default_nettype wire

/* src/sls_window.sv */
// Averaging window of the sound level smoother: sample memory and running sum.
// Standalone; instantiated by sound_level_smoother_unit.
`default_nettype none

module sls_window #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_refill,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [SUM_W-1:0]       o_sum
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [SAMPLE_BITS-1:0] r_fill;
    logic [SAMPLE_BITS-1:0] r_byp_data;
    logic                   r_byp_hit;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      n_slot;
    logic [WINDOW-1:0]      r_vld;
    logic [WINDOW-1:0]      n_vld;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic [SAMPLE_BITS-1:0] old_sample;

    always_comb begin
        if (!i_en) begin
            n_slot = r_slot;
        end else if (r_slot == LAST_SLOT) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + SLOT_W'(1);
        end
    end

    assign old_sample = r_byp_hit ? r_byp_data : (r_vld[r_slot] ? r_rd : r_fill);

    always_comb begin
        if (i_refill) begin
            n_sum = SUM_W'(SUM_W'(i_sample) * SUM_W'(WINDOW));
            n_vld = WINDOW'(1) << r_slot;
        end else begin
            n_sum = r_sum - SUM_W'(old_sample) + SUM_W'(i_sample);
            n_vld = r_vld | (WINDOW'(1) << r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[r_slot] <= i_sample;
        end
        r_rd       <= r_mem[n_slot];
        r_byp_data <= i_sample;
        if (i_en && i_refill) begin
            r_fill <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_vld     <= '0;
            r_byp_hit <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_slot    <= n_slot;
            r_byp_hit <= i_en && (n_slot == r_slot);
            if (i_en) begin
                r_vld <= n_vld;
                r_sum <= n_sum;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

/* src/sls_average.sv */
// Average level path: scales the window sum to dB and divides by the window depth.
// Uses sls_pkg; instantiated by sound_level_smoother_unit.
`default_nettype none

module sls_average #(
    parameter int WINDOW = 5,
    parameter int SUM_W  = 15
) (
    input  wire logic                          i_clk,
    input  wire sls_pkg::t_avg_en              i_en,
    input  wire logic [SUM_W-1:0]              i_sum,
    input  wire logic [sls_pkg::SCALE_W-1:0]   i_db_scale,
    output logic      [sls_pkg::DB_W-1:0]      o_avg
);

    import sls_pkg::*;

    localparam int P_W = SUM_W + SCALE_W;
    localparam int V_W = P_W - 16;
    localparam int VB  = 16 + $clog2(WINDOW);
    localparam int Q_W = 17;
    localparam logic [V_W-1:0] SAT_LIM = V_W'(WINDOW * 65536);
    localparam logic [Q_W-1:0] RECIP   = Q_W'((2 ** VB) / WINDOW);

    logic [P_W-1:0]     sum_prod;
    logic [V_W-1:0]     r_v;
    logic [VB+Q_W-1:0]  q_prod;
    logic               r_sat;
    logic [VB-1:0]      r_vn;
    logic [Q_W-1:0]     r_q0;
    logic [VB+Q_W-1:0]  qw_full;
    logic [VB-1:0]      rem;
    logic [Q_W-1:0]     q_fix;

    assign sum_prod = P_W'(i_sum) * P_W'(i_db_scale);
    assign q_prod   = (VB+Q_W)'(r_v[VB-1:0]) * (VB+Q_W)'(RECIP);
    assign qw_full  = (VB+Q_W)'(r_q0) * (VB+Q_W)'(WINDOW);
    assign rem      = r_vn - qw_full[VB-1:0];
    assign q_fix    = (rem >= VB'(WINDOW)) ? r_q0 + Q_W'(1) : r_q0;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_v <= sum_prod[P_W-1:16];
        end
        if (i_en.s4) begin
            r_sat <= (r_v >= SAT_LIM);
            r_vn  <= r_v[VB-1:0];
            r_q0  <= q_prod[VB+Q_W-1:VB];
        end
        if (i_en.s5) begin
            o_avg <= r_sat ? DB_MAX : q_fix[DB_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* src/sound_level_smoother_unit.sv */
// Sound level smoother: dB conversion, min/max, windowed average, hold and
// exponential smoothing. Uses sls_pkg, sls_window, sls_average and the macros header.
//
// Usage:
//   Input stream (s_axis) carries one raw sample per item in tdata. Output
//   stream (m_axis) returns one result item per input item, in order.
//   The cfg channel writes db_scale, jump_limit, hold_band and smooth_beta
//   by index; it is always ready and is to be written only while idle.
// Timing:
//   Six-stage pipeline (stages 0 to 5); a result is presented on m_axis from
//   the last stage. One item per cycle sustained while the receiver keeps
//   tready high; the level state (window, sum, hold, smoother, min/max) is
//   updated in a single stage per item.
// Reset:
//   Synchronous, active low. Clears the pipeline, the window state and the
//   smoother, and loads the register defaults. Min restarts at all ones.
// Stall:
//   When the receiver holds tready low, the output item stays; empty stages
//   ahead of it still fill, and s_axis tready drops once every stage is full.
`default_nettype none

`include "sound_level_smoother_unit_macros.svh"

module sound_level_smoother_unit #(
    parameter int WINDOW      = sls_pkg::DEFAULT_WINDOW,
    parameter int SAMPLE_BITS = sls_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // s_axis tdata: sample
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // m_axis tdata: db_now, db_average, db_hold, db_smooth, raw_min, raw_max
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic [((4*sls_pkg::DB_W+2*SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [sls_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [sls_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    import sls_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int OUT_W = ((4*DB_W + 2*SAMPLE_BITS + 7)/8)*8;
    localparam int P_W   = SAMPLE_BITS + SCALE_W;
    localparam int H_W   = P_W - 16;
    localparam int X_W   = ACC_W + BETA_W + 1;
    localparam int NSTG  = 6;

    logic [SCALE_W-1:0] r_db_scale;
    logic [LIMIT_W-1:0] r_jump_limit;
    logic [LIMIT_W-1:0] r_hold_band;
    logic [BETA_W-1:0]  r_beta;
    logic [BETA_W-1:0]  cfg_beta;

    logic [NSTG-1:0]        r_vld;
    logic [NSTG-1:0]        adv;
    logic                   state_en;
    t_avg_en                avg_en;

    logic [SAMPLE_BITS-1:0] r_s0;
    logic [SAMPLE_BITS-1:0] r_s1;
    logic [DB_W-1:0]        r_db1;
    logic [P_W-1:0]         db_prod;
    logic [H_W-1:0]         db_hi;
    logic [DB_W-1:0]        db_sat;

    logic                   r_primed;
    logic [DB_W-1:0]        r_prev_db;
    logic [DB_W-1:0]        r_held;
    logic [ACC_W-1:0]       r_acc;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [DB_W-1:0]        db_diff;
    logic                   refill;
    logic signed [ACC_W:0]  acc_err;
    logic signed [X_W-1:0]  err_x;
    logic signed [X_W-1:0]  beta_x;
    logic signed [X_W-1:0]  acc_prod;
    logic signed [X_W-1:0]  acc_sum;
    logic [ACC_W-1:0]       n_acc;

    logic [SUM_W-1:0]       win_sum;
    logic [DB_W-1:0]        avg_db;

    logic [DB_W-1:0]        r_db_c     [3];
    logic [DB_W-1:0]        r_hold_c   [3];
    logic [DB_W-1:0]        r_smooth_c [3];
    logic [SAMPLE_BITS-1:0] r_min_c    [3];
    logic [SAMPLE_BITS-1:0] r_max_c    [3];

    // configuration
    assign o_cfg_ready = 1'b1;
    assign cfg_beta    = (i_cfg_data[BETA_W-1:0] > BETA_ONE) ? BETA_ONE
                                                             : i_cfg_data[BETA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_scale   <= RST_DB_SCALE;
            r_jump_limit <= RST_JUMP_LIMIT;
            r_hold_band  <= RST_HOLD_BAND;
            r_beta       <= RST_BETA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DB_SCALE:    r_db_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_JUMP_LIMIT:  r_jump_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_HOLD_BAND:   r_hold_band  <= i_cfg_data[LIMIT_W-1:0];
                CFG_SMOOTH_BETA: r_beta       <= cfg_beta;
                default: ;
            endcase
        end
    end

    // stage flow control: a stage advances when empty or when the next one advances
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_s_axis_tready = adv[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign state_en        = adv[2] && r_vld[1];
    assign avg_en          = '{s3: adv[3], s4: adv[4], s5: adv[5]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0/1: capture sample, convert to dB
    assign db_prod = P_W'(r_s0) * P_W'(r_db_scale);
    assign db_hi   = db_prod[P_W-1:16];
    assign db_sat  = (db_hi > H_W'(DB_MAX)) ? DB_MAX : db_hi[DB_W-1:0];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0 <= i_s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (adv[1]) begin
            r_s1  <= r_s0;
            r_db1 <= db_sat;
        end
    end

    // stage 2: level state update
    assign db_diff = (r_db1 > r_prev_db) ? r_db1 - r_prev_db : r_prev_db - r_db1;
    assign refill  = !r_primed || (db_diff > r_jump_limit);

    assign acc_err  = $signed({1'b0, r_db1, ACC_FRAC'(0)}) - $signed({1'b0, r_acc});
    assign err_x    = X_W'(acc_err);
    assign beta_x   = $signed(X_W'(r_beta));
    assign acc_prod = err_x * beta_x;
    assign acc_sum  = $signed(X_W'(r_acc)) + (acc_prod >>> 16);
    assign n_acc    = acc_sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed  <= 1'b0;
            r_prev_db <= '0;
            r_held    <= '0;
            r_acc     <= '0;
            r_min     <= '1;
            r_max     <= '0;
        end else if (state_en) begin
            r_primed  <= 1'b1;
            r_prev_db <= r_db1;
            r_acc     <= n_acc;
            if (db_diff >= r_hold_band) begin
                r_held <= r_db1;
            end
            if (r_s1 < r_min) begin
                r_min <= r_s1;
            end
            if (r_s1 > r_max) begin
                r_max <= r_s1;
            end
        end
    end

    sls_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (state_en),
        .i_refill (refill),
        .i_sample (r_s1),
        .o_sum    (win_sum)
    );

    // stages 3..5: average path and carried fields
    sls_average #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_average (
        .i_clk      (i_clk),
        .i_en       (avg_en),
        .i_sum      (win_sum),
        .i_db_scale (r_db_scale),
        .o_avg      (avg_db)
    );

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_db_c[0]     <= r_prev_db;
            r_hold_c[0]   <= r_held;
            r_smooth_c[0] <= r_acc[ACC_W-1:ACC_FRAC];
            r_min_c[0]    <= r_min;
            r_max_c[0]    <= r_max;
        end
        for (int k = 1; k < 3; k++) begin
            if (adv[k+3]) begin
                r_db_c[k]     <= r_db_c[k-1];
                r_hold_c[k]   <= r_hold_c[k-1];
                r_smooth_c[k] <= r_smooth_c[k-1];
                r_min_c[k]    <= r_min_c[k-1];
                r_max_c[k]    <= r_max_c[k-1];
            end
        end
    end

    assign o_m_axis_tdata = OUT_W'({r_max_c[2], r_min_c[2], r_smooth_c[2],
                                    r_hold_c[2], avg_db, r_db_c[2]});

    `SLS_ASSERT(a_min_le_max, i_clk, i_rst_n, !o_m_axis_tvalid || (r_min_c[2] <= r_max_c[2]), "raw_min above raw_max")
    `SLS_ASSERT(a_stall_full, i_clk, i_rst_n, o_s_axis_tready || (&r_vld), "input stalled with a free stage")
    `SLS_ASSERT_NEXT(a_primed, i_clk, i_rst_n, state_en, r_primed, "window not primed after an item")

endmodule

`default_nettype wire

/* tb/sound_level_smoother_unit_checker.sv */
// Scoreboard for the sound level smoother: follows the register, sample and result channels.
// It predicts each result and compares it field by field with what the block returns.
// Depends on sls_pkg for the widths, reset values and register indexes.
module sound_level_smoother_unit_checker #(
    parameter int S_W = ((sls_pkg::DEFAULT_SAMPLE_BITS + 7) / 8) * 8,
    parameter int M_W = ((4 * sls_pkg::DB_W + 2 * sls_pkg::DEFAULT_SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    input  wire logic                            i_s_axis_tready,
    input  wire logic [S_W-1:0]                  i_s_axis_tdata,
    input  wire logic                            i_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic [M_W-1:0]                  i_m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [sls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                   o_failures,
    output int                                   o_pending,
    output int                                   o_results
);

    localparam int WIN = sls_pkg::DEFAULT_WINDOW;
    localparam int SB  = sls_pkg::DEFAULT_SAMPLE_BITS;
    localparam int DW  = sls_pkg::DB_W;

    typedef struct packed {
        logic [DW-1:0] db_now;
        logic [DW-1:0] db_average;
        logic [DW-1:0] db_hold;
        logic [DW-1:0] db_smooth;
        logic [SB-1:0] raw_min;
        logic [SB-1:0] raw_max;
    } levels_t;

    levels_t expected_levels[$];

    logic [sls_pkg::SCALE_W-1:0] cur_scale;
    logic [sls_pkg::LIMIT_W-1:0] cur_jump;
    logic [sls_pkg::LIMIT_W-1:0] cur_band;
    logic [sls_pkg::BETA_W-1:0]  cur_beta;

    logic [SB-1:0]               lvl_window [WIN];
    logic [14:0]                 lvl_sum;
    int unsigned                 next_slot;
    logic                        warmed;
    logic [DW-1:0]               prev_level;
    logic [DW-1:0]               held_level;
    logic [sls_pkg::ACC_W-1:0]   ema_acc;
    logic [SB-1:0]               low_sample;
    logic [SB-1:0]               high_sample;

    initial begin
        o_failures = 0;
        o_pending  = 0;
        o_results  = 0;
    end

    task automatic report_failure(input string msg);
        if (o_failures < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        o_failures++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want) begin
            report_failure($sformatf("result %0d %s: got %0d, expected %0d",
                                     o_results, name, got, want));
        end
    endtask

    function automatic logic [DW-1:0] clamp_level(input logic [63:0] v);
        return (v > 64'(sls_pkg::DB_MAX)) ? sls_pkg::DB_MAX : v[DW-1:0];
    endfunction

    task automatic reset_levels();
        cur_scale   = sls_pkg::RST_DB_SCALE;
        cur_jump    = sls_pkg::RST_JUMP_LIMIT;
        cur_band    = sls_pkg::RST_HOLD_BAND;
        cur_beta    = sls_pkg::RST_BETA;
        for (int k = 0; k < WIN; k++) begin
            lvl_window[k] = '0;
        end
        lvl_sum     = '0;
        next_slot   = 0;
        warmed      = 1'b0;
        prev_level  = '0;
        held_level  = '0;
        ema_acc     = '0;
        low_sample  = '1;
        high_sample = '0;
        expected_levels.delete();
    endtask

    task automatic predict_levels(input logic [SB-1:0] s, output levels_t r);
        logic [DW-1:0]             db;
        logic [DW-1:0]             delta;
        logic [sls_pkg::BETA_W-1:0] b;
        logic [63:0]               acc_next;
        db    = clamp_level((64'(s) * 64'(cur_scale)) >> 16);
        delta = (db > prev_level) ? db - prev_level : prev_level - db;
        if (s > high_sample) high_sample = s;
        if (s < low_sample) low_sample = s;
        // refill the whole window on the first item or on a level jump
        if (!warmed || delta > cur_jump) begin
            for (int k = 0; k < WIN; k++) begin
                lvl_window[k] = s;
            end
            lvl_sum = 15'(64'(s) * WIN);
        end
        lvl_sum = lvl_sum - lvl_window[next_slot] + 15'(s);
        lvl_window[next_slot] = s;
        next_slot = (next_slot + 1 >= WIN) ? 0 : next_slot + 1;
        warmed = 1'b1;
        r.db_average = clamp_level(((64'(lvl_sum) * 64'(cur_scale)) >> 16) / WIN);
        if (delta >= cur_band) held_level = db;
        b = (cur_beta > sls_pkg::BETA_ONE) ? sls_pkg::BETA_ONE : cur_beta;
        acc_next = (64'(ema_acc) * (64'(sls_pkg::BETA_ONE) - 64'(b))
                    + (64'(db) << sls_pkg::ACC_FRAC) * 64'(b)) >> 16;
        ema_acc = acc_next[sls_pkg::ACC_W-1:0];
        prev_level = db;
        r.db_now    = db;
        r.db_hold   = held_level;
        r.db_smooth = ema_acc[sls_pkg::ACC_FRAC +: DW];
        r.raw_min   = low_sample;
        r.raw_max   = high_sample;
    endtask

    always @(posedge i_clk) begin : monitor
        levels_t want;
        levels_t got;
        if (!i_rst_n) begin
            reset_levels();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sls_pkg::CFG_DB_SCALE:    cur_scale = i_cfg_data[sls_pkg::SCALE_W-1:0];
                    sls_pkg::CFG_JUMP_LIMIT:  cur_jump  = i_cfg_data[sls_pkg::LIMIT_W-1:0];
                    sls_pkg::CFG_HOLD_BAND:   cur_band  = i_cfg_data[sls_pkg::LIMIT_W-1:0];
                    sls_pkg::CFG_SMOOTH_BETA: cur_beta  = i_cfg_data[sls_pkg::BETA_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.db_now     = i_m_axis_tdata[0 +: DW];
                got.db_average = i_m_axis_tdata[DW +: DW];
                got.db_hold    = i_m_axis_tdata[2*DW +: DW];
                got.db_smooth  = i_m_axis_tdata[3*DW +: DW];
                got.raw_min    = i_m_axis_tdata[4*DW +: SB];
                got.raw_max    = i_m_axis_tdata[4*DW+SB +: SB];
                if (expected_levels.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with no item pending",
                                             o_results));
                end else begin
                    want = expected_levels.pop_front();
                    check_field("db_now", got.db_now, want.db_now);
                    check_field("db_average", got.db_average, want.db_average);
                    check_field("db_hold", got.db_hold, want.db_hold);
                    check_field("db_smooth", got.db_smooth, want.db_smooth);
                    check_field("raw_min", got.raw_min, want.raw_min);
                    check_field("raw_max", got.raw_max, want.raw_max);
                end
                o_results++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_levels(i_s_axis_tdata[SB-1:0], want);
                expected_levels.push_back(want);
            end
        end
        o_pending = expected_levels.size();
    end

endmodule

/* tb/sound_level_smoother_unit_tb.sv */
// Testbench top for the sound level smoother: clock, reset, register writes and sample stimulus.
// It also drives receiver back-pressure and gives the final verdict.
// Depends on sls_pkg, sound_level_smoother_unit and sound_level_smoother_unit_checker.
module sound_level_smoother_unit_tb;

    localparam int SB           = sls_pkg::DEFAULT_SAMPLE_BITS;
    localparam int S_W          = ((SB + 7) / 8) * 8;
    localparam int M_W          = ((4 * sls_pkg::DB_W + 2 * SB + 7) / 8) * 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int QUIET_CYCLES = 10;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 220;

    localparam logic [sls_pkg::CFG_IDX_W-1:0] CFG_NO_SUCH_REG = '1;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_IDLE,
        TRAFFIC_RECEIVER_STALL,
        TRAFFIC_BOTH
    } traffic_e;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [S_W-1:0]                  i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [M_W-1:0]                  o_m_axis_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sls_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [sls_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    int       failures;
    int       pending;
    int       results;
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    logic     hold_off = 1'b0;
    int       quiet_cycles = 0;
    int       samples_sent = 0;
    int       writes_done = 0;
    int       walk_level = 2048;

    always #2 i_clk = ~i_clk;

    sound_level_smoother_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    sound_level_smoother_unit_checker #(
        .S_W (S_W),
        .M_W (M_W)
    ) level_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_results       (results)
    );

    always @(posedge i_clk) begin
        if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d results pending",
                         STALL_LIMIT, pending);
                $display("sound_level_smoother_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic set_traffic(input traffic_e mode);
        case (mode)
            TRAFFIC_STEADY: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            TRAFFIC_SENDER_IDLE: begin
                sender_idle_pct = 68;
                receiver_stall_pct = 0;
            end
            TRAFFIC_RECEIVER_STALL: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 68;
            end
            default: begin
                sender_idle_pct = 31;
                receiver_stall_pct = 31;
            end
        endcase
    endtask

    task automatic hold_receiver(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off <= 1'b0;
    endtask

    task automatic send_sample(input logic [SB-1:0] s);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_W'(s);
        do @(posedge i_clk); while (!o_s_axis_tready);
        samples_sent++;
    endtask

    // drain the pipeline before touching a register
    task automatic write_register(input logic [sls_pkg::CFG_IDX_W-1:0] index,
                                  input logic [sls_pkg::CFG_DATA_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        writes_done++;
    endtask

    task automatic program_levels(input logic [23:0] scale, input logic [23:0] jump,
                                  input logic [23:0] band, input logic [23:0] beta);
        write_register(sls_pkg::CFG_DB_SCALE, scale);
        write_register(sls_pkg::CFG_JUMP_LIMIT, jump);
        write_register(sls_pkg::CFG_HOLD_BAND, band);
        write_register(sls_pkg::CFG_SMOOTH_BETA, beta);
    endtask

    // mostly realistic settings, sometimes the extremes; junk above the jump, band and beta widths
    task automatic random_levels();
        logic [23:0] scale;
        logic [23:0] jump;
        logic [23:0] band;
        logic [23:0] beta;
        logic [31:0] junk;
        junk = $urandom();
        case ($urandom_range(9))
            0: scale = '0;
            1: scale = '1;
            2: scale = 24'($urandom());
            default: scale = 24'($urandom_range(1 << 20));
        endcase
        case ($urandom_range(7))
            0: jump = 24'h0;
            1: jump = 24'hFFFF;
            default: jump = 24'($urandom_range(6000));
        endcase
        case ($urandom_range(7))
            0: band = 24'h0;
            1: band = 24'hFFFF;
            default: band = 24'($urandom_range(3000));
        endcase
        case ($urandom_range(7))
            0: beta = 24'h0;
            1: beta = 24'(sls_pkg::BETA_ONE);
            2: beta = 24'($urandom_range(65537, 131071));
            default: beta = 24'($urandom_range(1, 65535));
        endcase
        jump[23:16] = junk[7:0];
        band[23:16] = junk[15:8];
        beta[23:17] = junk[22:16];
        program_levels(scale, jump, band, beta);
    endtask

    task automatic next_sample(output logic [SB-1:0] s);
        int pick;
        int span;
        pick = $urandom_range(99);
        if (pick < 70) begin
            span = $urandom_range(40);
            walk_level = walk_level + $urandom_range(2 * span) - span;
            if (walk_level < 0) walk_level = 0;
            if (walk_level > 4095) walk_level = 4095;
        end else if (pick < 85) begin
            walk_level = $urandom_range(4095);
        end else if (pick < 92) begin
            walk_level = $urandom_range(1) ? 4095 : 0;
        end
        s = SB'(walk_level);
    endtask

    initial begin : stimulus
        logic [SB-1:0] s;
        set_traffic(TRAFFIC_STEADY);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: first item refills, then keep, step, jump and the extremes
        send_sample(12'd2000);
        send_sample(12'd2000);
        send_sample(12'd2010);
        send_sample(12'd2100);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd1);

        // all ones: saturated dB and average, beta above one, wide writes
        program_levels('1, '1, '1, '1);
        repeat (5) send_sample(12'd4095);
        send_sample(12'd0);

        // zero scale and zero beta; a write to a missing register is ignored
        program_levels('0, '0, '0, '0);
        write_register(CFG_NO_SUCH_REG, 24'($urandom()));
        send_sample(12'd4095);
        send_sample(12'd123);
        send_sample(12'd0);

        // beta exactly one, refill on every change
        program_levels(24'(sls_pkg::RST_DB_SCALE), '0, '0, 24'(sls_pkg::BETA_ONE));
        send_sample(12'd100);
        send_sample(12'd101);
        send_sample(12'd4000);
        send_sample(12'd3999);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                program_levels(24'(sls_pkg::RST_DB_SCALE), 24'(sls_pkg::RST_JUMP_LIMIT),
                               24'(sls_pkg::RST_HOLD_BAND), 24'(sls_pkg::RST_BETA));
            end else begin
                random_levels();
            end
            set_traffic(traffic_e'(p % 4));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == 40) begin
                    fork
                        hold_receiver(HOLD_CYCLES);
                    join_none
                end
                next_sample(s);
                send_sample(s);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d samples and %0d checked results over %0d register writes,",
                 samples_sent, results, writes_done);
        $display("across %0d traffic phases with one long receiver hold-off", PHASES);
        if (failures == 0) begin
            $display("sound_level_smoother_unit regression: pass");
        end else begin
            $display("sound_level_smoother_unit regression: fail");
        end
        $finish;
    end

endmodule
